/* rtl/core/metau_pkg.sv */
// shared types, constants and table function for the mixture entropy term accumulator
package metau_pkg;

   localparam int PROB_W       = 17;            // p_value / q_value width
   localparam int SUM_W        = PROB_W + 1;    // p + q
   localparam int LEAD_W       = $clog2(SUM_W); // leading-one index
   localparam int FRAC_W       = 30;            // Q0.30 fraction
   localparam int TAB_W        = 25;            // log2 table entry, Q1.24
   localparam int DIFF_W       = TAB_W + 1;
   localparam int EXP_W        = 7;             // signed exponent m - F - 1
   localparam int OPA_W        = 32;            // multiplier operand a, signed
   localparam int OPB_W        = 32;            // multiplier operand b, unsigned
   localparam int PROD_W       = 64;
   localparam int ACC_W        = 40;            // running sum, Q15.24
   localparam int ACC_EXT_W    = ACC_W + 2;
   localparam int OUT_W        = 32;            // divergence_sum, Q7.24
   localparam int REQ_DATA_W   = 40;            // 2 x 17 bits padded to bytes
   localparam int RSP_DATA_W   = 32;
   localparam int LOG_FRAC_POS = 24;

   localparam logic [OPB_W-1:0] LN2_Q30 = 32'd744261118;

   localparam int DEF_INPUT_FRACTION_BITS = 16;
   localparam int DEF_LOG_TABLE_ENTRIES   = 256;

   typedef enum logic [1:0] {
      MUL_OP_INDEX = 2'd0,   // fraction times table size
      MUL_OP_INTERP = 2'd1,  // table slope times remainder
      MUL_OP_LN = 2'd2,      // log2 times ln 2
      MUL_OP_TERM = 2'd3     // s times ln(u)
   } mul_op_type;

   typedef struct packed {
      logic       accept;
      logic       norm;
      logic       mul_en;
      mul_op_type mul_op;
      logic       rd_lo;
      logic       rd_hi;
      logic       combine;
      logic       accum;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic s_zero;
      logic last_item;
      logic out_free;
   } dp_status_type;

   // log2(x0 / 2^30) in Q0.24 by square-and-compare, x0 in Q1.30
   function automatic logic [TAB_W-1:0] log2_from_x(input logic [63:0] x0);
      logic [63:0]      x;
      logic [TAB_W-1:0] r;
      x = x0;
      r = '0;
      for (int k = 0; k < LOG_FRAC_POS; k++) begin
         x = (x * x) >> 30;
         r = {r[TAB_W-2:0], 1'b0};
         if (x >= 64'h0000_0000_8000_0000) begin
            r[0] = 1'b1;
            x    = x >> 1;
         end
      end
      return r;
   endfunction

endpackage

/* rtl/core/metau_ctrl.sv */
// sequencing state machine for the mixture entropy term accumulator
module metau_ctrl
   import metau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_NORM   = 11'b000_0000_0010,
      ST_MIDX   = 11'b000_0000_0100,
      ST_RDLO   = 11'b000_0000_1000,
      ST_RDHI   = 11'b000_0001_0000,
      ST_MFRAC  = 11'b000_0010_0000,
      ST_COMB   = 11'b000_0100_0000,
      ST_MLN    = 11'b000_1000_0000,
      ST_MTERM  = 11'b001_0000_0000,
      ST_ACCUM  = 11'b010_0000_0000,
      ST_EMIT   = 11'b100_0000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_op = MUL_OP_INDEX;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            // a zero pair adds nothing
            if (status.s_zero) begin
               state_in = status.last_item ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = ST_MIDX;
            end
         end
         ST_MIDX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_INDEX;
            state_in   = ST_RDLO;
         end
         ST_RDLO: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_RDHI;
         end
         ST_RDHI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_MFRAC;
         end
         ST_MFRAC: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_INTERP;
            state_in   = ST_COMB;
         end
         ST_COMB: begin
            cmd.combine = 1'b1;
            state_in    = ST_MLN;
         end
         ST_MLN: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_LN;
            state_in   = ST_MTERM;
         end
         ST_MTERM: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_TERM;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.last_item ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // wait until the output register can take the sum
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/metau_datapath.sv */
// log lookup, shared multiplier, accumulator and output register
module metau_datapath
   import metau_pkg::*;
#(
   parameter int INPUT_FRACTION_BITS = DEF_INPUT_FRACTION_BITS,
   parameter int LOG_TABLE_ENTRIES   = DEF_LOG_TABLE_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [PROB_W-1:0]       p_value,
   input  logic [PROB_W-1:0]       q_value,
   input  logic                    last_element,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] divergence_sum,
   output logic                    saturated
);

   localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);

   localparam logic signed [ACC_EXT_W-1:0] ACC_MAX = ACC_EXT_W'((64'sd1 <<< (ACC_W - 1)) - 1);
   localparam logic signed [ACC_EXT_W-1:0] ACC_MIN = ACC_EXT_W'(-(64'sd1 <<< (ACC_W - 1)));
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));
   localparam logic signed [EXP_W-1:0] EXP_BIAS = EXP_W'(INPUT_FRACTION_BITS + 1);

   // log2(1 + i/N) table, Q1.24
   logic [TAB_W-1:0] log_tab [LOG_TABLE_ENTRIES + 1];

   for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_tab
      localparam logic [63:0] X0 =
         ((64'(LOG_TABLE_ENTRIES) + 64'(g)) << 30) / 64'(LOG_TABLE_ENTRIES);
      assign log_tab[g] = log2_from_x(X0);
   end
   assign log_tab[LOG_TABLE_ENTRIES] = TAB_W'(1 << LOG_FRAC_POS);

   logic [SUM_W-1:0]              s_ff, s_in;
   logic                          last_ff, last_in;
   logic [LEAD_W-1:0]             m_ff, m_in;
   logic [FRAC_W-1:0]             fr_ff, fr_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [FRAC_W-1:0]             rem_ff, rem_in;
   logic [TAB_W-1:0]              lo_ff, lo_in;
   logic signed [DIFF_W-1:0]      diff_ff, diff_in;
   logic signed [OPA_W-1:0]       l2_ff, l2_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          ovf_ff, ovf_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]       rsp_sum_ff, rsp_sum_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   logic [LEAD_W-1:0]             lead;
   logic [SUM_W-1:0]              frac;
   logic [SUM_W+FRAC_W-1:0]       fr_wide;
   logic [IDX_W-1:0]              tab_addr;
   logic [TAB_W-1:0]              tab_q;
   logic signed [OPA_W-1:0]       mul_a;
   logic [OPB_W-1:0]              mul_b;
   logic signed [EXP_W-1:0]       exp_s;
   logic signed [ACC_EXT_W-1:0]   acc_sum;
   logic signed [ACC_EXT_W-1:0]   term;

   // leading one of s
   always_comb begin
      lead = '0;
      for (int b = 0; b < SUM_W; b++) begin
         if (s_ff[b]) begin
            lead = LEAD_W'(b);
         end
      end
   end

   assign frac    = s_ff & ~(SUM_W'(1) << lead);
   assign fr_wide = {frac, {FRAC_W{1'b0}}} >> lead;

   // one table read per cycle: low entry, then the next one
   assign tab_addr = cmd.rd_hi ? IDX_W'(idx_ff + IDX_W'(1)) : prod_ff[FRAC_W +: IDX_W];
   assign tab_q    = log_tab[tab_addr];

   assign exp_s = $signed({{(EXP_W - LEAD_W){1'b0}}, m_ff}) - EXP_BIAS;

   always_comb begin
      case (cmd.mul_op)
         MUL_OP_INDEX: begin
            mul_a = $signed(OPA_W'(fr_ff));
            mul_b = OPB_W'(LOG_TABLE_ENTRIES);
         end
         MUL_OP_INTERP: begin
            mul_a = OPA_W'(diff_ff);
            mul_b = OPB_W'(rem_ff);
         end
         MUL_OP_LN: begin
            mul_a = l2_ff;
            mul_b = LN2_Q30;
         end
         default: begin
            mul_a = OPA_W'(prod_ff >>> FRAC_W);
            mul_b = OPB_W'(s_ff);
         end
      endcase
   end

   assign term    = ACC_EXT_W'(prod_ff >>> (INPUT_FRACTION_BITS + 1));
   assign acc_sum = ACC_EXT_W'(acc_ff) + term;

   always_comb begin
      s_in         = s_ff;
      last_in      = last_ff;
      m_in         = m_ff;
      fr_in        = fr_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      diff_in      = diff_ff;
      l2_in        = l2_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         s_in    = SUM_W'(p_value) + SUM_W'(q_value);
         last_in = last_element;
      end
      if (cmd.norm) begin
         m_in  = lead;
         fr_in = fr_wide[FRAC_W-1:0];
      end
      if (cmd.mul_en) begin
         prod_in = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
      end
      if (cmd.rd_lo) begin
         idx_in = prod_ff[FRAC_W +: IDX_W];
         rem_in = prod_ff[FRAC_W-1:0];
         lo_in  = tab_q;
      end
      if (cmd.rd_hi) begin
         diff_in = $signed({1'b0, tab_q}) - $signed({1'b0, lo_ff});
      end
      if (cmd.combine) begin
         l2_in = $signed(OPA_W'(lo_ff)) + OPA_W'(prod_ff >>> FRAC_W)
               + (OPA_W'(exp_s) <<< LOG_FRAC_POS);
      end
      if (cmd.accum) begin
         if (acc_sum > ACC_MAX) begin
            acc_in = ACC_MAX[ACC_W-1:0];
            ovf_in = 1'b1;
         end else if (acc_sum < ACC_MIN) begin
            acc_in = ACC_MIN[ACC_W-1:0];
            ovf_in = 1'b1;
         end else begin
            acc_in = acc_sum[ACC_W-1:0];
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (acc_ff > OUT_MAX) begin
            rsp_sum_in = OUT_MAX[OUT_W-1:0];
            rsp_sat_in = 1'b1;
         end else if (acc_ff < OUT_MIN) begin
            rsp_sum_in = OUT_MIN[OUT_W-1:0];
            rsp_sat_in = 1'b1;
         end else begin
            rsp_sum_in = acc_ff[OUT_W-1:0];
            rsp_sat_in = ovf_ff;
         end
         acc_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      m_ff       <= m_in;
      fr_ff      <= fr_in;
      idx_ff     <= idx_in;
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      diff_ff    <= diff_in;
      l2_ff      <= l2_in;
      prod_ff    <= prod_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign status.s_zero    = (s_ff == '0);
   assign status.last_item = last_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign divergence_sum = rsp_sum_ff;
   assign saturated      = rsp_sat_ff;

endmodule

/* rtl/core/mixture_entropy_term_accumulator_unit.sv */
// channel | dir | tdata (low bit first)               | tuser     | tlast
// req     | in  | p_value[16:0], q_value[33:17], pad  | -         | last_element
// rsp     | out | divergence_sum[31:0]                | saturated | -
//
// after a nonzero pair is accepted the input stays closed through the normalize,
// multiply, table read, combine and accumulate states: the u*ln(u) chain runs through
// one shared 32x33 multiplier four times and reads the log2 table twice over a single
// read port; a pair with p and q both zero skips every step after normalize, and a last
// word goes through the emit state to load the sum; reset clears the running sum,
// the overflow flag and the output valid flag; a stalled result holds in the output
// register; input is still taken until the next sum is ready and finds it full
module mixture_entropy_term_accumulator_unit
   import metau_pkg::*;
#(
   parameter int INPUT_FRACTION_BITS = DEF_INPUT_FRACTION_BITS,
   parameter int LOG_TABLE_ENTRIES   = DEF_LOG_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // p_value[16:0], q_value[33:17], zero[39:34]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // divergence_sum[31:0]
   output logic                  rsp_tuser    // saturated[0]
);

   dp_cmd_type              dp_cmd;
   dp_status_type           dp_status;
   logic signed [OUT_W-1:0] sum_out;

   metau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   metau_datapath #(
      .INPUT_FRACTION_BITS (INPUT_FRACTION_BITS),
      .LOG_TABLE_ENTRIES   (LOG_TABLE_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .p_value        (req_tdata[PROB_W-1:0]),
      .q_value        (req_tdata[2*PROB_W-1:PROB_W]),
      .last_element   (req_tlast),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .divergence_sum (sum_out),
      .saturated      (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(sum_out);

   // one word at a time: after acceptance the input closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while previous word still in work");

   // a sum leaves only for a word flagged last
   a_emit_on_last: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> dp_status.last_item)
      else $error("sum emitted without a last word");

   // a pending result is never overwritten
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> dp_status.out_free)
      else $error("result register overwritten while stalled");

   // the accumulator step only follows the term multiply
   a_accum_order: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.accum |-> $past(dp_cmd.mul_en) && $past(dp_cmd.mul_op) == MUL_OP_TERM)
      else $error("accumulate without a term product");

endmodule

/* verif/mixture_entropy_sum_checker.sv */
// checker: predicts the u*ln(u) sums from accepted pairs and compares each returned sum
`timescale 1ns / 100ps

module mixture_entropy_sum_checker
   import metau_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // p_value[16:0], q_value[33:17], zero[39:34]
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // divergence_sum[31:0]
   input  logic                  rsp_tuser,   // saturated[0]
   output int                    mismatch_count,
   output int                    pending_sums,
   output int                    sums_checked,
   output int                    clamped_sums
);

   localparam int     FRAC_BITS  = DEF_INPUT_FRACTION_BITS;
   localparam int     TABLE_N    = DEF_LOG_TABLE_ENTRIES;
   localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_BOTTOM = -(longint'(1) <<< (ACC_W - 1));
   localparam longint OUT_TOP    = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint OUT_BOTTOM = -(longint'(1) <<< (OUT_W - 1));

   typedef struct packed {
      logic signed [OUT_W-1:0] sum;
      logic                    saturated;
   } sum_word_type;

   longint       log2_q24 [0:TABLE_N];
   sum_word_type expected_sums [$];
   longint       mix_sum      = 0;
   logic         mix_overflow = 1'b0;
   int           errors       = 0;
   int           checked      = 0;
   int           clamped      = 0;

   initial mismatch_count = 0;
   initial pending_sums   = 0;
   initial sums_checked   = 0;
   initial clamped_sums   = 0;

   // log2(1 + i/N) in Q0.24 by repeated squaring of x in Q1.30
   initial begin : build_log2
      longint unsigned x;
      longint unsigned bits;
      for (int i = 0; i < TABLE_N; i++) begin
         x    = longint'(TABLE_N + i) << 30;
         x    = x / TABLE_N;
         bits = 0;
         repeat (LOG_FRAC_POS) begin
            x    = (x * x) >> 30;
            bits = bits << 1;
            if (x >= (64'd1 << 31)) begin
               bits = bits | 64'd1;
               x    = x >> 1;
            end
         end
         log2_q24[i] = longint'(bits);
      end
      log2_q24[TABLE_N] = longint'(1) <<< LOG_FRAC_POS;
   end

   // u*ln(u) in Q.24 for u = s / 2^(F+1), s nonzero
   function automatic longint ulogu_q24(input logic [SUM_W-1:0] s);
      int              lead;
      longint unsigned frac_q30;
      longint unsigned scaled;
      longint unsigned idx;
      longint unsigned rem;
      longint          lo;
      longint          hi;
      longint          l2;
      longint          lnu;
      lead = 0;
      for (int b = 0; b < SUM_W; b++)
         if (s[b])
            lead = b;
      frac_q30 = (longint'(s) - (longint'(1) << lead)) << (FRAC_W - lead);
      scaled   = frac_q30 * TABLE_N;
      idx      = scaled >> FRAC_W;
      rem      = scaled & ((64'd1 << FRAC_W) - 1);
      if (idx >= TABLE_N) begin
         idx = TABLE_N - 1;
         rem = (64'd1 << FRAC_W) - 1;
      end
      lo  = log2_q24[idx];
      hi  = log2_q24[idx + 1];
      l2  = lo + (((hi - lo) * longint'(rem)) >>> FRAC_W);
      l2  = l2 + longint'(lead - FRAC_BITS - 1) * (longint'(1) <<< LOG_FRAC_POS);
      lnu = (l2 * longint'(LN2_Q30)) >>> FRAC_W;
      return (longint'(s) * lnu) >>> (FRAC_BITS + 1);
   endfunction

   always @(posedge clock) begin : track
      logic [PROB_W-1:0] p_in;
      logic [PROB_W-1:0] q_in;
      longint            acc;
      sum_word_type      want;
      if (reset) begin
         mix_sum      = 0;
         mix_overflow = 1'b0;
         expected_sums.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            p_in = req_tdata[PROB_W-1:0];
            q_in = req_tdata[2*PROB_W-1:PROB_W];
            if (p_in != '0 || q_in != '0) begin
               acc = mix_sum + ulogu_q24({1'b0, p_in} + {1'b0, q_in});
               if (acc > ACC_TOP) begin
                  acc          = ACC_TOP;
                  mix_overflow = 1'b1;
               end else if (acc < ACC_BOTTOM) begin
                  acc          = ACC_BOTTOM;
                  mix_overflow = 1'b1;
               end
               mix_sum = acc;
            end
            if (req_tlast) begin
               acc            = mix_sum;
               want.saturated = mix_overflow;
               if (acc > OUT_TOP) begin
                  acc            = OUT_TOP;
                  want.saturated = 1'b1;
               end else if (acc < OUT_BOTTOM) begin
                  acc            = OUT_BOTTOM;
                  want.saturated = 1'b1;
               end
               want.sum = acc[OUT_W-1:0];
               expected_sums.push_back(want);
               mix_sum      = 0;
               mix_overflow = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: sum word with none expected: expected none, actual %0d sat %b",
                        $time, $signed(rsp_tdata), rsp_tuser);
               errors++;
            end else begin
               want = expected_sums.pop_front();
               checked++;
               if (want.saturated)
                  clamped++;
               if (rsp_tdata !== want.sum) begin
                  $display("%0t: divergence_sum mismatch: expected %0d, actual %0d",
                           $time, want.sum, $signed(rsp_tdata));
                  errors++;
               end
               if (rsp_tuser !== want.saturated) begin
                  $display("%0t: saturated mismatch: expected %b, actual %b",
                           $time, want.saturated, rsp_tuser);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_sums   <= expected_sums.size();
      sums_checked   <= checked;
      clamped_sums   <= clamped;
   end

endmodule

/* verif/tb_mixture_entropy_term_accumulator_unit.sv */
// top of the testbench: clock, reset, pair stimulus, result back-pressure and verdict
`timescale 1ns / 100ps

module tb_mixture_entropy_term_accumulator_unit;
   import metau_pkg::*;

   localparam int RANDOM_WORDS = 180;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 40;
   localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;
   localparam logic [PROB_W-1:0] PROB_MAX = 17'h1FFFF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int req_idle_max = 0;
   int rsp_idle_max = 0;
   int rsp_hold     = 0;
   int words_sent   = 0;
   int vectors_sent = 0;
   int mismatch_count;
   int pending_sums;
   int sums_checked;
   int clamped_sums;

   mixture_entropy_term_accumulator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mixture_entropy_sum_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_sums   (pending_sums),
      .sums_checked   (sums_checked),
      .clamped_sums   (clamped_sums)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stall after each sum word
   always @(posedge clock) begin : rsp_side
      int next_hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         next_hold = $urandom_range(rsp_idle_max, 0);
         rsp_hold   <= next_hold;
         rsp_tready <= (next_hold == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_mixture_entropy_term_accumulator_unit: FAIL");
      $finish;
   end

   task automatic send_word(input logic [PROB_W-1:0] p_val, input logic [PROB_W-1:0] q_val,
                            input logic last);
      int gap;
      gap = $urandom_range(req_idle_max, 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 2*PROB_W){1'b0}}, q_val, p_val};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (last)
         vectors_sent++;
   endtask

   // one vector of len pairs drawn near the given base values
   task automatic send_run(input int p_base, input int q_base, input int spread, input int len);
      for (int k = 0; k < len; k++)
         send_word(PROB_W'(p_base + $urandom_range(spread, 0)),
                   PROB_W'(q_base + $urandom_range(spread, 0)), k == len - 1);
   endtask

   // sender holds off until every sum has come back
   task automatic drain_sums();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sums != 0)
         @(posedge clock);
   endtask

   function automatic logic [PROB_W-1:0] draw_value();
      int kind;
      kind = $urandom_range(99, 0);
      if (kind < 15)
         return '0;
      else if (kind < 30)
         return PROB_W'($urandom_range(15, 0));
      else if (kind < 75)
         return PROB_W'($urandom_range(65536, 0));
      else if (kind < 92)
         return PROB_W'($urandom_range(131071, 0));
      else
         return PROB_W'(1) << $urandom_range(PROB_W - 1, 0);
   endfunction

   function automatic int draw_idle();
      case ($urandom_range(2, 0))
         0: return 0;
         1: return 3;
         default: return 12;
      endcase
   endfunction

   initial begin : stimulus
      int first_random;
      int len;
      int p_left;
      int q_left;
      logic [PROB_W-1:0] p_val;
      logic [PROB_W-1:0] q_val;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_max = 2;
      rsp_idle_max <= 2;
      send_word('0, '0, 1'b1);                    // vector of zeros only
      send_word('0, 17'd1, 1'b0);                 // smallest sums
      send_word(17'd1, '0, 1'b0);
      send_word(17'd1, 17'd1, 1'b1);
      send_word(PROB_ONE, PROB_ONE, 1'b1);        // u exactly one
      send_word(PROB_MAX, PROB_MAX, 1'b1);        // largest u
      send_word(PROB_ONE, '0, 1'b0);
      send_word('0, PROB_ONE, 1'b0);
      send_word('0, '0, 1'b0);
      send_word(17'd32768, 17'd32768, 1'b1);
      send_word(PROB_MAX, '0, 1'b0);              // values above one
      send_word('0, PROB_MAX, 1'b1);
      send_word(17'd24110, 17'd24110, 1'b0);      // zero pair inside a vector
      send_word('0, '0, 1'b0);
      send_word(17'd12345, 17'd54321, 1'b1);
      send_word(17'h15555, 17'h0AAAA, 1'b0);
      send_word(17'h0AAAA, 17'h15555, 1'b1);
      send_word(17'd1000, 17'd2000, 1'b0);        // last word is a zero pair
      send_word('0, '0, 1'b1);
      send_word(17'd1, '0, 1'b1);
      drain_sums();

      // long vectors: output clamp high, output clamp low
      req_idle_max = 0;
      rsp_idle_max <= 0;
      send_run(PROB_MAX, PROB_MAX, 0, 100);
      req_idle_max = 3;
      rsp_idle_max <= 12;
      send_run(24000, 24000, 220, 400);
      drain_sums();

      first_random = words_sent;
      while (words_sent - first_random < RANDOM_WORDS) begin
         if ($urandom_range(3, 0) == 0) begin
            req_idle_max = draw_idle();
            rsp_idle_max <= draw_idle();
         end
         len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         if ($urandom_range(2, 0) != 0) begin
            // pair of pmfs, each summing to one
            p_left = 65536;
            q_left = 65536;
            for (int k = 0; k < len; k++) begin
               if (k == len - 1) begin
                  p_val = PROB_W'(p_left);
                  q_val = PROB_W'(q_left);
               end else begin
                  p_val = PROB_W'($urandom_range(p_left, 0));
                  q_val = PROB_W'($urandom_range(q_left, 0));
                  p_left -= p_val;
                  q_left -= q_val;
               end
               send_word(p_val, q_val, k == len - 1);
            end
         end else begin
            for (int k = 0; k < len; k++)
               send_word(draw_value(), draw_value(), k == len - 1);
         end
         if (vectors_sent % 50 == 0)
            drain_sums();
      end

      drain_sums();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d pair words in %0d vectors: edge pairs, long clamping vectors,",
               words_sent, vectors_sent);
      $display("random pmf pairs and unnormalized pairs; %0d sums checked, %0d of them clamped",
               sums_checked, clamped_sums);
      if (mismatch_count == 0 && pending_sums == 0)
         $display("tb_mixture_entropy_term_accumulator_unit: PASS");
      else
         $display("tb_mixture_entropy_term_accumulator_unit: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/metau_pkg.sv
rtl/core/metau_ctrl.sv
rtl/core/metau_datapath.sv
rtl/core/mixture_entropy_term_accumulator_unit.sv
verif/mixture_entropy_sum_checker.sv
verif/tb_mixture_entropy_term_accumulator_unit.sv
